FILE: sv/mbpf_pkg.sv
package mbpf_pkg;

	localparam int ByteW    = 8;
	localparam int RegW     = 64;
	localparam int AddrW    = 32;
	localparam int LenRegW  = 5;
	localparam int AlignW   = 4;
	localparam int CfgIdxW  = 3;
	localparam int PatBytes = 16;
	localparam int PatW     = PatBytes * ByteW;

	localparam logic [LenRegW-1:0] LenReset   = 5'd16;
	localparam logic [AlignW-1:0]  AlignReset = 4'd1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PATTERN_LOW,
		REG_PATTERN_HIGH,
		REG_MASK_LOW,
		REG_MASK_HIGH,
		REG_PATTERN_LENGTH,
		REG_ALIGN_LOG2,
		REG_BASE_ADDRESS
	} cfg_reg_t;

	// qualifiers of the candidate start position, combined into a hit in the top level
	typedef struct packed {
		logic fits;     // enough bytes seen and start offset in range
		logic aligned;  // start address meets the alignment
		logic bytes_eq; // window equals pattern outside the don't-care bits
	} cmp_status_t;

endpackage

FILE: sv/mbpf_match.sv
module mbpf_match
	import mbpf_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int OFFSET_BITS = 20
) (
	input  logic [ByteW-1:0]   window [MAX_PATTERN_BYTES],
	input  logic [OFFSET_BITS:0] bytes_seen,
	input  logic [PatW-1:0]    pattern,
	input  logic [PatW-1:0]    mask,
	input  logic [LenRegW-1:0] pattern_length,
	input  logic [AlignW-1:0]  align_log2,
	input  logic [AddrW-1:0]   base_address,
	output cmp_status_t        status,
	output logic [OFFSET_BITS:0] start
);

	localparam int CntW = OFFSET_BITS + 1;
	localparam int LenW = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [LenW-1:0]       len;
	logic [CntW+AddrW-1:0] start_ext;
	logic [AddrW-1:0]      addr;
	logic [AddrW-1:0]      align_mask;
	logic                  bytes_eq;

	always_comb begin
		priority if (pattern_length == '0) begin
			len = LenW'(1);
		end else if (pattern_length > LenRegW'(MAX_PATTERN_BYTES)) begin
			len = LenW'(MAX_PATTERN_BYTES);
		end else begin
			len = LenW'(pattern_length);
		end
	end

	assign start      = bytes_seen - CntW'(len);
	assign start_ext  = (CntW + AddrW)'(start);
	assign addr       = base_address + start_ext[AddrW-1:0];
	assign align_mask = ~({AddrW{1'b1}} << align_log2);

	assign status.fits     = (bytes_seen >= CntW'(len)) && !start[OFFSET_BITS];
	assign status.aligned  = (addr & align_mask) == '0;
	assign status.bytes_eq = bytes_eq;

	// pattern byte k lines up with window slot MAX - len + k
	always_comb begin
		logic [LenW:0]  pos;
		logic [ByteW-1:0] w;
		bytes_eq = 1'b1;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			pos = (LenW + 1)'(MAX_PATTERN_BYTES) - {1'b0, len} + (LenW + 1)'(k);
			w   = window[pos[IdxW-1:0]];
			if ((LenW + 1)'(k) < {1'b0, len}) begin
				if (((w ^ pattern[k*ByteW +: ByteW]) & ~mask[k*ByteW +: ByteW]) != '0) begin
					bytes_eq = 1'b0;
				end
			end
		end
	end

endmodule

FILE: sv/masked_byte_pattern_finder.sv
// An accepted byte enters the window register; the result register then drives m_tvalid.
// Throughput: one byte per cycle; the window compare between the input window register
// and the result register is a single pass, so s_tready stays high unless the result stalls.
// At most one result per region: the first aligned match, or found=0 on the last byte.
// Reset (arst_n low, asynchronous) empties the pipeline and window and restores register defaults.
module masked_byte_pattern_finder
	import mbpf_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int OFFSET_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,

	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [RegW-1:0]    cfg_data,

	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ByteW-1:0] s_tdata,  // [7:0] data_byte
	input  logic             s_tlast,  // last_byte

	output logic m_tvalid,
	input  logic m_tready,
	output logic [((OFFSET_BITS + 7) / 8) * 8 - 1:0] m_tdata, // match_offset, zero padded
	output logic m_tuser  // found
);

	localparam int CntW = OFFSET_BITS + 1;
	localparam int OutW = ((OFFSET_BITS + 7) / 8) * 8;

	logic [RegW-1:0]    pattern_low_q, pattern_high_q, mask_low_q, mask_high_q;
	logic [LenRegW-1:0] pattern_length_q;
	logic [AlignW-1:0]  align_log2_q;
	logic [AddrW-1:0]   base_address_q;

	logic [ByteW-1:0] window_q [MAX_PATTERN_BYTES];
	logic [CntW-1:0]  bytes_seen_q;
	logic             match_reported_q;
	logic             valid_s1, last_s1;

	logic                   out_valid_q, found_q;
	logic [OFFSET_BITS-1:0] offset_q;

	logic        accept, s1_adv, region_end, hit, res_valid;
	logic [CntW-1:0] start;
	logic [CntW-1:0] seen_base;
	cmp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			mask_low_q       <= '0;
			mask_high_q      <= '0;
			pattern_length_q <= LenReset;
			align_log2_q     <= AlignReset;
			base_address_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_MASK_LOW:       mask_low_q       <= cfg_data;
				REG_MASK_HIGH:      mask_high_q      <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LenRegW-1:0];
				REG_ALIGN_LOG2:     align_log2_q     <= cfg_data[AlignW-1:0];
				REG_BASE_ADDRESS:   base_address_q   <= cfg_data[AddrW-1:0];
				default: ;
			endcase
		end
	end

	assign s1_adv     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || s1_adv;
	assign accept     = s_tvalid && s_tready;
	assign region_end = s1_adv && last_s1;

	mbpf_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_match (
		.window(window_q),
		.bytes_seen(bytes_seen_q),
		.pattern({pattern_high_q, pattern_low_q}),
		.mask({mask_high_q, mask_low_q}),
		.pattern_length(pattern_length_q),
		.align_log2(align_log2_q),
		.base_address(base_address_q),
		.status(status),
		.start(start)
	);

	assign hit       = !match_reported_q && status.fits && status.aligned && status.bytes_eq;
	assign res_valid = hit || (last_s1 && !match_reported_q);
	assign seen_base = region_end ? '0 : bytes_seen_q;

	// window and count follow accepted bytes; a region end restarts them from empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= '0;
			end
			bytes_seen_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
				window_q[i] <= region_end ? '0 : window_q[i+1];
			end
			window_q[MAX_PATTERN_BYTES-1] <= s_tdata;
			if (seen_base != '1) begin
				bytes_seen_q <= seen_base + CntW'(1);
			end else begin
				bytes_seen_q <= seen_base;
			end
		end else if (region_end) begin
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= '0;
			end
			bytes_seen_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			last_s1          <= 1'b0;
			match_reported_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				last_s1  <= s_tlast;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				match_reported_q <= last_s1 ? 1'b0 : (match_reported_q || hit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			found_q  <= hit;
			offset_q <= hit ? start[OFFSET_BITS-1:0] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = OutW'(offset_q);

endmodule
